@@ hdl/urx_pkg.sv @@
// Package with shared types and constants for the UART receiver with FIFO.
package urx_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } rx_phase_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEWLINE_EVENT_ENABLE = 2'd2;

  localparam logic [15:0] TICKS_PER_BIT_RST = 16'd104;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam int unsigned AVAIL_W = 6;

  typedef struct packed {
    logic       done;
    logic [7:0] data;
  } urx_frame_st_t;

endpackage

@@ hdl/urx_in_if.sv @@
// Input channel interface: one receive tick per beat.
interface urx_in_if;
  logic valid;
  logic ready;
  logic rx_level;
  logic pop_req;
  logic take_overrun;

  modport source (output valid, output rx_level, output pop_req, output take_overrun,
                  input ready);
  modport sink (input valid, input rx_level, input pop_req, input take_overrun,
                output ready);
endinterface

@@ hdl/urx_out_if.sv @@
// Result channel interface: one result per beat.
interface urx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       read_valid;
  logic [5:0] available;
  logic       overrun;
  logic       byte_done;
  logic       line_end;

  modport source (output valid, output read_byte, output read_valid, output available,
                  output overrun, output byte_done, output line_end, input ready);
  modport sink (input valid, input read_byte, input read_valid, input available,
                input overrun, input byte_done, input line_end, output ready);
endinterface

@@ hdl/urx_frame.sv @@
// Frame sampler: start detection, bit timing and the data shift register.
module urx_frame (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   rx_level,
  input  logic [15:0]            ticks_per_bit,
  input  logic                   rx_enable,
  output urx_pkg::urx_frame_st_t st
);
  import urx_pkg::*;

  rx_phase_t   phase_r, phase_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        line_prev_r, line_prev_nxt;
  logic [15:0] cnt_inc;
  logic [15:0] half;
  logic        done;

  assign cnt_inc = cnt_r + 16'd1;
  assign half = {1'b0, ticks_per_bit[15:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r <= '0;
      bit_r <= '0;
      shift_r <= '0;
      line_prev_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
      bit_r <= bit_nxt;
      shift_r <= shift_nxt;
      line_prev_r <= line_prev_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt = cnt_r;
    bit_nxt = bit_r;
    shift_nxt = shift_r;
    line_prev_nxt = line_prev_r;
    done = 1'b0;
    if (step) begin
      line_prev_nxt = rx_level;
      case (phase_r)
        PH_IDLE: begin
          if (rx_enable && line_prev_r && !rx_level) begin
            phase_nxt = PH_START;
            cnt_nxt = '0;
            bit_nxt = '0;
            shift_nxt = '0;
          end
        end
        PH_START: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= half) begin
            phase_nxt = PH_DATA;
            cnt_nxt = '0;
          end
        end
        PH_DATA: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= ticks_per_bit) begin
            cnt_nxt = '0;
            shift_nxt = {rx_level, shift_r[7:1]};
            if (bit_r == 3'd7) begin
              done = 1'b1;
              bit_nxt = '0;
              phase_nxt = PH_STOP;
            end else begin
              bit_nxt = bit_r + 3'd1;
            end
          end
        end
        PH_STOP: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= half) begin
            phase_nxt = PH_IDLE;
            cnt_nxt = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  assign st.done = done;
  assign st.data = shift_nxt;

endmodule

@@ hdl/uart_rx_with_fifo.sv @@
// Top level: 8N1 serial receiver with a receive FIFO held in a synchronous memory.
//
//  Channel  Direction  Handshake       Beat contents
//  in_ch    sink       valid/ready     rx_level, pop_req, take_overrun
//  out_ch   source     valid/ready     read_byte, read_valid, available, overrun,
//                                      byte_done, line_end
//  cfg_*    sink       cfg_we          cfg_index, cfg_data
//
// One input beat is taken every clock cycle unless in_ch is stalled; its result
// appears in the next cycle, when the FIFO memory's registered read data is ready.
// Pointers, overrun flag and frame state update at the accepting edge; the memory is
// written with a received byte and read at the read pointer on that same edge.
// A result waiting on out_ch stalls in_ch only while out_ch.ready is low.
// Reset is synchronous; the FIFO memory is not cleared and needs no clearing pass.
module uart_rx_with_fifo #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  urx_in_if.sink                          in_ch,
  urx_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [urx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [urx_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import urx_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);

  logic [15:0] tpb_r;
  logic        rx_en_r;
  logic        nl_en_r;

  logic [7:0]       mem [FIFO_DEPTH];
  logic [7:0]       rd_data_r;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic             ovr_r, ovr_nxt;

  logic             out_valid_r;
  logic             rvalid_r;
  logic [AVAIL_W-1:0] avail_r;
  logic             ovr_out_r;
  logic             done_r;
  logic             lend_r;

  logic             fire;
  logic             pop_ok;
  logic             push;
  logic             lend;
  logic [PTR_W-1:0] wp_inc;
  logic [CNT_W-1:0] avail;
  urx_frame_st_t    fst;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpb_r <= TICKS_PER_BIT_RST;
      rx_en_r <= 1'b1;
      nl_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS_PER_BIT: tpb_r <= cfg_data[15:0];
        CFG_RX_ENABLE: rx_en_r <= cfg_data[0];
        CFG_NEWLINE_EVENT_ENABLE: nl_en_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  urx_frame u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (fire),
    .rx_level      (in_ch.rx_level),
    .ticks_per_bit (tpb_r),
    .rx_enable     (rx_en_r),
    .st            (fst)
  );

  always_comb begin
    pop_ok = in_ch.pop_req && (rp_r != wp_r);
    rp_nxt = pop_ok ? ptr_next(rp_r) : rp_r;
    wp_inc = ptr_next(wp_r);
    push = fst.done && (wp_inc != rp_nxt);
    wp_nxt = push ? wp_inc : wp_r;
    ovr_nxt = in_ch.take_overrun ? 1'b0 : ovr_r;
    if (fst.done && !push) begin
      ovr_nxt = 1'b1;
    end
    lend = fst.done && nl_en_r && (fst.data == NEWLINE_BYTE);
    if (wp_nxt >= rp_nxt) begin
      avail = CNT_W'(wp_nxt) - CNT_W'(rp_nxt);
    end else begin
      avail = CNT_W'(wp_nxt) + DEPTH_C - CNT_W'(rp_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && push) begin
      mem[wp_r] <= fst.data;
    end
    if (fire) begin
      rd_data_r <= mem[rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= '0;
      wp_r <= '0;
      ovr_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        rp_r <= rp_nxt;
        wp_r <= wp_nxt;
        ovr_r <= ovr_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rvalid_r <= pop_ok;
      avail_r <= AVAIL_W'(avail);
      ovr_out_r <= ovr_r;
      done_r <= fst.done;
      lend_r <= lend;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.read_byte = rvalid_r ? rd_data_r : 8'd0;
  assign out_ch.read_valid = rvalid_r;
  assign out_ch.available = avail_r;
  assign out_ch.overrun = ovr_out_r;
  assign out_ch.byte_done = done_r;
  assign out_ch.line_end = lend_r;

endmodule
